### design/smam_pkg.sv
`default_nettype none

package smam_pkg;

	// Field widths fixed by the beat formats
	localparam int CH_BITS     = 2;
	localparam int SMOOTH_BITS = 11;
	localparam int LEVEL_BITS  = 16;
	localparam int WL_BITS     = 8;
	localparam int SCALE_BITS  = 20;

	// Configuration port
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = SCALE_BITS;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_WINDOW_LENGTH,
		REG_LEVEL_SCALE
	} cfg_reg_t;

	localparam logic [WL_BITS-1:0]    WINDOW_LENGTH_RST = 8'd250;
	localparam logic [SCALE_BITS-1:0] LEVEL_SCALE_RST   = 20'd88388;

	// Smoothing filter (-3, 12, 17, 12, -3) / 35
	localparam int TAPS       = 5;
	localparam int COEF_EDGE  = 3;
	localparam int COEF_MID   = 12;
	localparam int COEF_CTR   = 17;
	localparam int SMOOTH_DIV = 35;

	localparam logic [SMOOTH_BITS-1:0] SMOOTH_MAX = '1;

	// Level = (max - min) * scale >> 10, saturated
	localparam int LEVEL_SHIFT = 10;

	// Per-channel window state as kept in the window memory
	typedef struct packed {
		logic [WL_BITS-1:0]     cnt;
		logic [SMOOTH_BITS-1:0] win_min;
		logic [SMOOTH_BITS-1:0] win_max;
		logic [LEVEL_BITS-1:0]  lvl;
	} win_state_t;

endpackage

`default_nettype wire

### design/smam_ram.sv
`default_nettype none

module smam_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire             clk,
	input  wire             we,
	input  wire  [AW-1:0]   waddr,
	input  wire  [WIDTH-1:0] wdata,
	input  wire             re,
	input  wire  [AW-1:0]   raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Registered read; a read of the entry being written returns the old word
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

`default_nettype wire

### design/multichannel_smoothed_amplitude_meter_unit.sv
// Channel  Handshake            Beat
// in       in_valid / in_stall  channel, sample
// out      out_valid / out_stall out_channel, smoothed, window_done, level
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One sample per cycle while in_stall is low. Throughput is set by the per-channel state
// memories: history read at intake and rewritten in stage 1, window state read into
// stage 3 and rewritten from stage 5, with forwarding between beats of the same channel
// in flight. Reset clears the valid bits and restores the configuration registers only;
// an unwritten channel reads as all-zero state. A stalled result freezes the whole
// pipeline and raises in_stall. Configuration writes are taken on any cycle.
`default_nettype none

module multichannel_smoothed_amplitude_meter_unit #(
	parameter int NUM_CHANNELS = 4,
	parameter int SAMPLE_BITS  = 10
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  [smam_pkg::CH_BITS-1:0]          channel,
	input  wire  [SAMPLE_BITS-1:0]                sample,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic [smam_pkg::CH_BITS-1:0]          out_channel,
	output logic [smam_pkg::SMOOTH_BITS-1:0]      smoothed,
	output logic                                  window_done,
	output logic [smam_pkg::LEVEL_BITS-1:0]       level,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [smam_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire  [smam_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	import smam_pkg::*;

	localparam int AW         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int HIST_DEPTH = TAPS - 1;
	localparam int HW         = HIST_DEPTH * SAMPLE_BITS;
	localparam int ACC_W      = SAMPLE_BITS + 7;
	localparam int NUM_W      = ACC_W - 1;
	// Exact divide by 35: q = (a * ceil(2^S / 35)) >> S with S = NUM_W + clog2(35)
	localparam int DIV_SHIFT  = NUM_W + $clog2(SMOOTH_DIV);
	localparam int MUL_W      = DIV_SHIFT - $clog2(SMOOTH_DIV) + 2;
	localparam logic [MUL_W-1:0] DIV_M =
		MUL_W'(((64'd1 << DIV_SHIFT) + 64'(SMOOTH_DIV - 1)) / 64'(SMOOTH_DIV));
	localparam int PROD_W     = NUM_W + MUL_W;
	localparam int Q_W        = PROD_W - DIV_SHIFT;
	localparam int WIN_W      = $bits(win_state_t);
	localparam int SCALED_W   = SMOOTH_BITS + SCALE_BITS;
	localparam int SHIFTED_W  = SCALED_W - LEVEL_SHIFT;

	typedef logic [HIST_DEPTH-1:0][SAMPLE_BITS-1:0] hist_t;

	// Configuration registers
	logic [WL_BITS-1:0]    wl_q;
	logic [SCALE_BITS-1:0] scale_q;

	// Pipeline control
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// Pipeline payload
	logic               ok_s1, ok_s2, ok_s3, ok_s4, ok_s5;
	logic [CH_BITS-1:0] ch_s1, ch_s2, ch_s3, ch_s4, ch_s5, ch_s6;
	logic [SAMPLE_BITS-1:0] smp_s1;
	logic               hv_s1, wv_s3;
	hist_t              hist_s2;
	logic signed [ACC_W-1:0] acc_s2;
	logic [SMOOTH_BITS-1:0]  val_s3, val_s4, val_s5, val_s6;
	logic               done_s4, done_s5, done_s6;
	logic [SMOOTH_BITS-1:0]  range_s4;
	win_state_t         st_s4, st_s5;
	logic [SCALED_W-1:0] scaled_s5;
	logic [LEVEL_BITS-1:0] lvl_s6;

	// Valid bits of the state memories and the last window-state write
	logic [NUM_CHANNELS-1:0] h_vld_q, w_vld_q;
	logic               lw_v_q;
	logic [CH_BITS-1:0] lw_ch_q;
	win_state_t         lw_st_q;

	// Memory ports
	logic [HW-1:0]    h_rdata;
	logic             h_we;
	logic [WIN_W-1:0] w_rdata;
	logic             w_we;

	// Combinational stage results
	logic                    ok_in;
	hist_t                   hist_old, hist_new;
	logic signed [ACC_W-1:0] tap_v [TAPS];
	logic signed [ACC_W-1:0] acc_c;
	logic [PROD_W-1:0]       quot_prod;
	logic [Q_W-1:0]          quot;
	logic [SMOOTH_BITS-1:0]  val_c;
	win_state_t              cur_st, st_new;
	logic [LEVEL_BITS-1:0]   prev_lvl_a;
	logic                    first_smp;
	logic [SMOOTH_BITS-1:0]  min_n, max_n, range_c;
	logic [WL_BITS-1:0]      cnt_inc;
	logic                    done_c;
	win_state_t              st_fwd;
	logic [SCALED_W-1:0]     scaled_c;
	logic [SHIFTED_W-1:0]    shifted;
	logic [LEVEL_BITS-1:0]   lvl_new_s5;
	win_state_t              wr_st;

	// Whole pipeline moves unless a finished result is held
	assign adv       = !v_s6 || !out_stall;
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;
	assign ok_in     = 32'(channel) < 32'(NUM_CHANNELS);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q    <= WINDOW_LENGTH_RST;
			scale_q <= LEVEL_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH: wl_q    <= cfg_data[WL_BITS-1:0];
				REG_LEVEL_SCALE:   scale_q <= cfg_data[SCALE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// History memory: read at intake, rewritten in stage 1
	assign h_we = adv && v_s1 && ok_s1;

	smam_ram #(
		.WIDTH (HW),
		.DEPTH (NUM_CHANNELS)
	) u_hist_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (AW'(ch_s1)),
		.wdata (HW'(hist_new)),
		.re    (adv),
		.raddr (AW'(channel)),
		.rdata (h_rdata)
	);

	// Window memory: read into stage 3, rewritten from stage 5
	assign w_we = adv && v_s5 && ok_s5;

	smam_ram #(
		.WIDTH (WIN_W),
		.DEPTH (NUM_CHANNELS)
	) u_win_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (AW'(ch_s5)),
		.wdata (WIN_W'(wr_st)),
		.re    (adv),
		.raddr (AW'(ch_s2)),
		.rdata (w_rdata)
	);

	// Stage 1: history resolve and filter sum
	always_comb begin
		hist_old = hv_s1 ? hist_t'(h_rdata) : '0;
		// previous beat of this channel wrote as this one read
		if (v_s2 && ok_s2 && ch_s2 == ch_s1) begin
			hist_old = hist_s2;
		end
		for (int k = 0; k < HIST_DEPTH - 1; k++) begin
			hist_new[k] = hist_old[k+1];
		end
		hist_new[HIST_DEPTH-1] = smp_s1;
		for (int k = 0; k < HIST_DEPTH; k++) begin
			tap_v[k] = $signed(ACC_W'(hist_old[k]));
		end
		tap_v[TAPS-1] = $signed(ACC_W'(smp_s1));
		acc_c = ACC_W'(COEF_MID * (tap_v[1] + tap_v[3]) + COEF_CTR * tap_v[2]
			- COEF_EDGE * (tap_v[0] + tap_v[4]));
	end

	// Stage 2: divide by 35, clamp
	always_comb begin
		quot_prod = PROD_W'(acc_s2[NUM_W-1:0]) * PROD_W'(DIV_M);
		quot      = quot_prod[PROD_W-1:DIV_SHIFT];
		if (acc_s2 <= 0) begin
			val_c = '0;
		end else if (32'(quot) > 32'(SMOOTH_MAX)) begin
			val_c = SMOOTH_MAX;
		end else begin
			val_c = SMOOTH_BITS'(quot);
		end
	end

	// Stage 3: window state resolve and min/max update
	always_comb begin
		cur_st = wv_s3 ? win_state_t'(w_rdata) : '0;
		if (lw_v_q && lw_ch_q == ch_s3) begin
			cur_st = lw_st_q;
		end
		prev_lvl_a = cur_st.lvl;
		// earlier beats still in flight carry count and extremes
		if (v_s5 && ok_s5 && ch_s5 == ch_s3) begin
			cur_st = st_s5;
		end
		if (v_s4 && ok_s4 && ch_s4 == ch_s3) begin
			cur_st = st_s4;
		end
		first_smp = cur_st.cnt == '0;
		if (first_smp || val_s3 < cur_st.win_min) begin
			min_n = val_s3;
		end else begin
			min_n = cur_st.win_min;
		end
		if (first_smp || val_s3 > cur_st.win_max) begin
			max_n = val_s3;
		end else begin
			max_n = cur_st.win_max;
		end
		cnt_inc = cur_st.cnt + 1'b1;
		done_c  = (cnt_inc >= wl_q) || (cnt_inc == '0);
		range_c = max_n - min_n;
		st_new.cnt     = done_c ? '0 : cnt_inc;
		st_new.win_min = min_n;
		st_new.win_max = max_n;
		st_new.lvl     = prev_lvl_a;
	end

	// Stage 4: level forwarding and scale product
	always_comb begin
		st_fwd = st_s4;
		if (lw_v_q && lw_ch_q == ch_s4) begin
			st_fwd.lvl = lw_st_q.lvl;
		end
		if (v_s5 && ok_s5 && ch_s5 == ch_s4) begin
			st_fwd.lvl = lvl_new_s5;
		end
		scaled_c = SCALED_W'(range_s4) * SCALED_W'(scale_q);
	end

	// Stage 5: shift, saturate, write back
	always_comb begin
		shifted = scaled_s5[SCALED_W-1:LEVEL_SHIFT];
		if (!done_s5) begin
			lvl_new_s5 = st_s5.lvl;
		end else if (|shifted[SHIFTED_W-1:LEVEL_BITS]) begin
			lvl_new_s5 = '1;
		end else begin
			lvl_new_s5 = shifted[LEVEL_BITS-1:0];
		end
		wr_st     = st_s5;
		wr_st.lvl = lvl_new_s5;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			lw_v_q  <= 1'b0;
			h_vld_q <= '0;
			w_vld_q <= '0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			if (h_we) begin
				h_vld_q[AW'(ch_s1)] <= 1'b1;
			end
			if (w_we) begin
				w_vld_q[AW'(ch_s5)] <= 1'b1;
				lw_v_q              <= 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s1  <= ok_in;
			ch_s1  <= channel;
			smp_s1 <= sample;
			hv_s1  <= ok_in ? h_vld_q[AW'(channel)] : 1'b0;

			ok_s2   <= ok_s1;
			ch_s2   <= ch_s1;
			hist_s2 <= hist_new;
			acc_s2  <= acc_c;

			ok_s3  <= ok_s2;
			ch_s3  <= ch_s2;
			val_s3 <= val_c;
			wv_s3  <= ok_s2 ? w_vld_q[AW'(ch_s2)] : 1'b0;

			ok_s4    <= ok_s3;
			ch_s4    <= ch_s3;
			val_s4   <= val_s3;
			done_s4  <= done_c;
			range_s4 <= range_c;
			st_s4    <= st_new;

			ok_s5     <= ok_s4;
			ch_s5     <= ch_s4;
			val_s5    <= val_s4;
			done_s5   <= done_s4;
			st_s5     <= st_fwd;
			scaled_s5 <= scaled_c;

			ch_s6   <= ch_s5;
			val_s6  <= ok_s5 ? val_s5 : '0;
			done_s6 <= ok_s5 && done_s5;
			lvl_s6  <= ok_s5 ? lvl_new_s5 : '0;

			if (w_we) begin
				lw_ch_q <= ch_s5;
				lw_st_q <= wr_st;
			end
		end
	end

	assign out_valid   = v_s6;
	assign out_channel = ch_s6;
	assign smoothed    = val_s6;
	assign window_done = done_s6;
	assign level       = lvl_s6;

`ifndef SYNTHESIS
	// out-of-range channels report zeros
	a_bad_channel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && 32'(out_channel) >= 32'(NUM_CHANNELS)
		|-> smoothed == '0 && !window_done && level == '0)
		else $error("nonzero result for out-of-range channel");

	// state memories are never written for an out-of-range channel
	a_no_bad_write: assert property (@(posedge clk) disable iff (!arst_n)
		(h_we || w_we) |-> (!h_we || 32'(ch_s1) < 32'(NUM_CHANNELS))
		&& (!w_we || 32'(ch_s5) < 32'(NUM_CHANNELS)))
		else $error("state write for out-of-range channel");

	// a closed window restarts its count, an open one never sits at zero
	a_count_restart: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && ok_s4 |-> done_s4 == (st_s4.cnt == '0))
		else $error("window count inconsistent with window close");

	// a held result freezes the stages behind it
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(v_s5) && $stable(ch_s5) && $stable(st_s5))
		else $error("pipeline moved under output stall");
`endif

endmodule

`default_nettype wire

### bench/tb.sv
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import smam_pkg::*;

	localparam int NUM_CH      = 4;
	localparam int SAMPLE_BITS = 10;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [CH_BITS-1:0]     ch;
		logic [SMOOTH_BITS-1:0] smoothed;
		logic                   done;
		logic [LEVEL_BITS-1:0]  lvl;
	} meter_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [CH_BITS-1:0]        channel = '0;
	logic [SAMPLE_BITS-1:0]    sample = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [CH_BITS-1:0]        out_channel;
	logic [SMOOTH_BITS-1:0]    smoothed;
	logic                      window_done;
	logic [LEVEL_BITS-1:0]     level;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	// Idle control shared by both sides; hold_cycles asks the receiver for a long stall
	logic steady = 1'b0;
	int   hold_cycles = 0;
	int   failures = 0;
	int   cycles = 0;

	meter_result_t meter_expect[$];

	// Shadow of the block: configuration and per-channel window state
	logic [WL_BITS-1:0]     shadow_wl = WINDOW_LENGTH_RST;
	logic [SCALE_BITS-1:0]  shadow_scale = LEVEL_SCALE_RST;
	logic [SAMPLE_BITS-1:0] taps_hist [NUM_CH][TAPS];
	logic [WL_BITS-1:0]     win_cnt [NUM_CH];
	logic [SMOOTH_BITS-1:0] win_lo [NUM_CH];
	logic [SMOOTH_BITS-1:0] win_hi [NUM_CH];
	logic [LEVEL_BITS-1:0]  ch_level [NUM_CH];

	multichannel_smoothed_amplitude_meter_unit #(
		.NUM_CHANNELS(NUM_CH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.channel    (channel),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_channel(out_channel),
		.smoothed   (smoothed),
		.window_done(window_done),
		.level      (level),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #4 clk = ~clk;

	// Run-length guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Filter, window min/max and level update for one accepted sample
	function automatic meter_result_t predict_meter(input logic [CH_BITS-1:0] ch,
			input logic [SAMPLE_BITS-1:0] smp);
		meter_result_t r;
		int acc;
		logic [SMOOTH_BITS-1:0] val;
		longint prod;
		for (int k = 0; k < TAPS - 1; k++)
			taps_hist[ch][k] = taps_hist[ch][k+1];
		taps_hist[ch][TAPS-1] = smp;
		acc = -COEF_EDGE * int'(taps_hist[ch][0]) + COEF_MID * int'(taps_hist[ch][1])
			+ COEF_CTR * int'(taps_hist[ch][2]) + COEF_MID * int'(taps_hist[ch][3])
			- COEF_EDGE * int'(taps_hist[ch][4]);
		if (acc <= 0)
			val = '0;
		else if (acc / SMOOTH_DIV > int'(SMOOTH_MAX))
			val = SMOOTH_MAX;
		else
			val = SMOOTH_BITS'(acc / SMOOTH_DIV);
		// first sample of a window seeds both bounds
		if (win_cnt[ch] == '0) begin
			win_lo[ch] = val;
			win_hi[ch] = val;
		end else begin
			if (val > win_hi[ch])
				win_hi[ch] = val;
			if (val < win_lo[ch])
				win_lo[ch] = val;
		end
		win_cnt[ch] = win_cnt[ch] + 1'b1;
		r.done = 1'b0;
		if (win_cnt[ch] >= shadow_wl || win_cnt[ch] == '0) begin
			prod = (longint'(win_hi[ch] - win_lo[ch]) * longint'(shadow_scale)) >>> LEVEL_SHIFT;
			ch_level[ch] = (prod > 65535) ? 16'hFFFF : LEVEL_BITS'(prod);
			win_cnt[ch] = '0;
			r.done = 1'b1;
		end
		r.ch = ch;
		r.smoothed = val;
		r.lvl = ch_level[ch];
		return r;
	endfunction

	// Sender: random gaps unless steady, then hold the beat until taken
	task automatic send_sample(input logic [CH_BITS-1:0] ch, input logic [SAMPLE_BITS-1:0] smp);
		while (!steady && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		channel <= ch;
		sample <= smp;
		do @(posedge clk); while (in_stall);
		meter_expect.push_back(predict_meter(ch, smp));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (meter_expect.size() != 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_WINDOW_LENGTH: shadow_wl = val[WL_BITS-1:0];
			REG_LEVEL_SCALE:   shadow_scale = val[SCALE_BITS-1:0];
			default:           ;
		endcase
	endtask

	// Receiver: random stalls, or a counted long hold when requested
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_cycles != 0) begin
				out_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles <= 0;
			end
			out_stall <= !steady && ($urandom_range(99) < 18);
		end
	end

	// Result checker against the oldest expectation
	always @(posedge clk) begin : result_check
		meter_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (meter_expect.size() == 0) begin
				$error("result beat with nothing expected: ch %0d", out_channel);
				failures++;
			end else begin
				want = meter_expect.pop_front();
				if (out_channel !== want.ch) begin
					$error("out_channel: expected %0d, got %0d", want.ch, out_channel);
					failures++;
				end
				if (smoothed !== want.smoothed) begin
					$error("smoothed: expected %0d, got %0d", want.smoothed, smoothed);
					failures++;
				end
				if (window_done !== want.done) begin
					$error("window_done: expected %0d, got %0d", want.done, window_done);
					failures++;
				end
				if (level !== want.lvl) begin
					$error("level: expected %0d, got %0d", want.lvl, level);
					failures++;
				end
			end
		end
	end

	// Full-scale steps, negative-sum clamp and bit patterns at reset settings
	task automatic test_filter_extremes();
		send_sample(2'd0, 10'd1023);
		send_sample(2'd1, 10'd0);
		send_sample(2'd0, 10'd1023);
		send_sample(2'd1, 10'd1023);
		send_sample(2'd0, 10'd1023);
		send_sample(2'd2, 10'h2AA);
		send_sample(2'd0, 10'd0);
		send_sample(2'd2, 10'h155);
		send_sample(2'd3, 10'd1023);
		send_sample(2'd0, 10'd0);
		send_sample(2'd3, 10'd0);
		send_sample(2'd3, 10'd1023);
		wait_drained();
	endtask

	// One-sample windows with the largest scale: range and level stay zero
	task automatic test_single_sample_window();
		write_reg(REG_WINDOW_LENGTH, 1);
		write_reg(REG_LEVEL_SCALE, 20'hFFFFF);
		send_sample(2'd1, 10'd1023);
		send_sample(2'd1, 10'd0);
		send_sample(2'd1, 10'd1023);
		send_sample(2'd2, 10'd512);
		wait_drained();
	endtask

	// Window length zero closes every sample; zero scale
	task automatic test_zero_window();
		write_reg(REG_WINDOW_LENGTH, 0);
		write_reg(REG_LEVEL_SCALE, 0);
		send_sample(2'd3, 10'd700);
		send_sample(2'd0, 10'd5);
		send_sample(2'd3, 10'd1);
		wait_drained();
	endtask

	// Longest window, then shortened below the running count
	task automatic test_window_shortened();
		write_reg(REG_WINDOW_LENGTH, 255);
		write_reg(REG_LEVEL_SCALE, LEVEL_SCALE_RST);
		send_sample(2'd2, 10'd100);
		send_sample(2'd2, 10'd900);
		send_sample(2'd2, 10'd300);
		send_sample(2'd2, 10'd1000);
		send_sample(2'd2, 10'd50);
		wait_drained();
		write_reg(REG_WINDOW_LENGTH, 2);
		send_sample(2'd2, 10'd600);
		wait_drained();
	endtask

	// Mostly bounded tones per channel, some full-range noise and rail hits
	task automatic send_tone_burst(input int n);
		logic [SAMPLE_BITS-1:0] center [NUM_CH];
		int span;
		logic [CH_BITS-1:0] ch;
		logic [SAMPLE_BITS-1:0] smp;
		span = $urandom_range(400, 8);
		foreach (center[c])
			center[c] = SAMPLE_BITS'($urandom_range(1023 - span));
		for (int i = 0; i < n; i++) begin
			ch = CH_BITS'($urandom_range(NUM_CH - 1));
			case ($urandom_range(9))
				0, 1:    smp = SAMPLE_BITS'($urandom_range(1023));
				2:       smp = $urandom_range(1) ? '1 : '0;
				default: smp = center[ch] + SAMPLE_BITS'($urandom_range(span));
			endcase
			send_sample(ch, smp);
		end
	endtask

	// Several window/scale settings, random content, one phase without idling
	task automatic test_random_windows();
		logic [WL_BITS-1:0] wl;
		logic [SCALE_BITS-1:0] scale;
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0:       wl = 1;
				3:       wl = 255;
				default: wl = WL_BITS'($urandom_range(16, 1));
			endcase
			case ($urandom_range(3))
				0:       scale = '1;
				1:       scale = SCALE_BITS'($urandom_range(2048));
				default: scale = SCALE_BITS'($urandom_range(20'hFFFFF));
			endcase
			write_reg(REG_WINDOW_LENGTH, wl);
			write_reg(REG_LEVEL_SCALE, scale);
			steady <= (phase == 2);
			send_tone_burst(phase == 3 ? 80 : 50);
			wait_drained();
		end
		steady <= 1'b0;
	endtask

	// Receiver holds off while samples keep coming: pipeline fills, input stalls
	task automatic test_backpressure();
		write_reg(REG_WINDOW_LENGTH, 4);
		write_reg(REG_LEVEL_SCALE, LEVEL_SCALE_RST);
		hold_cycles <= 200;
		steady <= 1'b1;
		send_tone_burst(40);
		steady <= 1'b0;
		wait_drained();
	endtask

	initial begin : run
		foreach (taps_hist[c, k])
			taps_hist[c][k] = '0;
		foreach (win_cnt[c]) begin
			win_cnt[c] = '0;
			win_lo[c] = '0;
			win_hi[c] = '0;
			ch_level[c] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_filter_extremes();
		test_single_sample_window();
		test_zero_window();
		test_window_shortened();
		test_random_windows();
		test_backpressure();

		wait_drained();
		repeat (12) @(posedge clk);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

### multichannel_smoothed_amplitude_meter_unit.f
design/smam_pkg.sv
design/smam_ram.sv
design/multichannel_smoothed_amplitude_meter_unit.sv
bench/tb.sv
